>>> rtl/bmp_to_mono_bitmap_converter_core_macros.svh
// Assertion macros for the BMP to mono bitmap converter.
// Included by the RTL files that assert; depends on nothing else.
`ifndef BMP_TO_MONO_BITMAP_CONVERTER_CORE_MACROS_SVH
`define BMP_TO_MONO_BITMAP_CONVERTER_CORE_MACROS_SVH

// Check a property every clock, held off during reset.
`define BMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property every clock, including during reset.
`define BMC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/bmc_pkg.sv
// Types and constants for the BMP to mono bitmap converter.
// No dependencies.
package bmc_pkg;

   localparam int unsigned PixelWidth   = 8;
   localparam int unsigned AddrWidth    = 13;
   localparam int unsigned DimWidth     = 8;
   localparam int unsigned BppWidth     = 3;
   localparam int unsigned SumWidth     = 10;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 8;

   // Register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_BYTES_PER_PIXEL = 2'd2;

   // Reset values of the registers
   localparam logic [DimWidth-1:0] RESET_IMAGE_WIDTH     = 8'd8;
   localparam logic [DimWidth-1:0] RESET_IMAGE_HEIGHT    = 8'd8;
   localparam logic [BppWidth-1:0] RESET_BYTES_PER_PIXEL = 3'd3;

   // One byte write of the output bitmap
   typedef struct packed {
      logic [AddrWidth-1:0]  byte_address;
      logic [PixelWidth-1:0] byte_value;
      logic                  last_of_image;
   } result_type;

endpackage

>>> rtl/bmp_to_mono_bitmap_converter_core.sv
// BMP to mono bitmap converter, top level.
// Depends on bmc_pkg and bmp_to_mono_bitmap_converter_core_macros.svh.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   req     | req_valid req_ready req_pixel_byte           | in
//   rsp     | rsp_valid rsp_ready rsp_byte_address ...     | out
//   csr     | csr_valid csr_ready csr_index csr_data       | in
//
// A byte write is registered into the output register, or the skid entry
// while rsp stalls, on the transfer that completes it. The per-byte update
// (a sum, one compare, counters and a small multiply for the row address)
// is combinational, so a byte can be taken on every clock while req_ready
// is high. An output register plus a skid entry hold results; req_ready
// drops only while both are full. Reset (synchronous) clears all counters
// and loads width 8, height 8 and 3 bytes per pixel. csr is always ready.
module bmp_to_mono_bitmap_converter_core #(
   parameter int unsigned MAX_ROW_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel byte input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bmc_pkg::PixelWidth-1:0]      req_pixel_byte,
   // byte write output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bmc_pkg::AddrWidth-1:0]       rsp_byte_address,
   output logic [bmc_pkg::PixelWidth-1:0]      rsp_byte_value,
   output logic                                rsp_last_of_image,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bmc_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [bmc_pkg::CsrDataWidth-1:0]    csr_data
);

`include "bmp_to_mono_bitmap_converter_core_macros.svh"

   localparam int unsigned RbWidth   = $clog2(MAX_ROW_BYTES + 1);
   localparam int unsigned ProdWidth = bmc_pkg::DimWidth + RbWidth + 1;
   localparam logic [RbWidth-1:0] RbMax = RbWidth'(MAX_ROW_BYTES);

   // Configuration registers
   logic [bmc_pkg::DimWidth-1:0] width_ff, width_in;
   logic [bmc_pkg::DimWidth-1:0] height_ff, height_in;
   logic [bmc_pkg::BppWidth-1:0] bpp_ff, bpp_in;

   // Walk state
   logic [bmc_pkg::DimWidth-1:0]   col_ff, col_in;
   logic [bmc_pkg::DimWidth-1:0]   row_ff, row_in;
   logic [1:0]                     bip_ff, bip_in;
   logic [bmc_pkg::SumWidth-1:0]   sum_ff, sum_in;
   logic [bmc_pkg::PixelWidth-1:0] acc_ff, acc_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [1:0]                     pad_ff, pad_in;

   // Result buffer: output register and skid entry
   bmc_pkg::result_type out_ff, out_in, skid_ff, skid_in;
   logic                out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   // Step logic
   logic                           req_xfer, rsp_xfer, push;
   logic [bmc_pkg::DimWidth-1:0]   eff_width;
   logic [2:0]                     eff_bpp;
   logic                           done;
   logic [bmc_pkg::SumWidth-1:0]   sum_next;
   logic [1:0]                     phase_next;
   logic [2:0]                     cnt;
   logic                           black, row_end;
   logic [bmc_pkg::PixelWidth-1:0] acc_next;
   logic [RbWidth-1:0]             row_bytes;
   logic [bmc_pkg::DimWidth-1:0]   flip_row;
   logic [ProdWidth-1:0]           addr_full;
   bmc_pkg::result_type            result;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = out_valid_ff && rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_byte_address  = out_ff.byte_address;
   assign rsp_byte_value    = out_ff.byte_value;
   assign rsp_last_of_image = out_ff.last_of_image;

   // Effective register values: zero width acts as one, bytes per pixel
   // clamps to one..four
   always_comb begin
      eff_width = (width_ff == '0) ? bmc_pkg::DimWidth'(1) : width_ff;
      if (bpp_ff == '0) begin
         eff_bpp = 3'd1;
      end else if (bpp_ff > 3'd4) begin
         eff_bpp = 3'd4;
      end else begin
         eff_bpp = bpp_ff;
      end
   end

   // Row address: flipped row times row bytes plus byte column
   always_comb begin
      logic [RbWidth:0] rb_raw;
      rb_raw    = (RbWidth + 1)'((({1'b0, eff_width} + 9'd7) >> 3));
      row_bytes = (rb_raw > {1'b0, RbMax}) ? RbMax : rb_raw[RbWidth-1:0];
      flip_row  = height_ff - 8'd1 - row_ff;
      addr_full = ProdWidth'(flip_row) * ProdWidth'(row_bytes)
                + ProdWidth'(col_ff[7:3]);
   end

   // Configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bmc_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_data;
            end
            bmc_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_data;
            end
            bmc_pkg::CSR_BYTES_PER_PIXEL: begin
               bpp_in = csr_data[bmc_pkg::BppWidth-1:0];
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // Per-byte walk: skip padding, sum pixel bytes, threshold, pack bits
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      bip_in   = bip_ff;
      sum_in   = sum_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      pad_in   = pad_ff;
      push     = 1'b0;

      done       = row_ff >= height_ff;
      sum_next   = sum_ff + bmc_pkg::SumWidth'(req_pixel_byte);
      phase_next = phase_ff + 2'd1;
      cnt        = {1'b0, bip_ff} + 3'd1;
      black      = sum_next < {eff_bpp, 7'd0};
      acc_next   = acc_ff | (bmc_pkg::PixelWidth'(black) << col_ff[2:0]);
      row_end    = ({1'b0, col_ff} + 9'd1) >= {1'b0, eff_width};

      result.byte_address  = addr_full[bmc_pkg::AddrWidth-1:0];
      result.byte_value    = acc_next;
      result.last_of_image = row_end && (({1'b0, row_ff} + 9'd1) >= {1'b0, height_ff});

      if (req_xfer && !done) begin
         phase_in = phase_next;
         if (pad_ff != 2'd0) begin
            // padding byte: count it down and drop it
            pad_in = pad_ff - 2'd1;
         end else if (cnt < eff_bpp) begin
            sum_in = sum_next;
            bip_in = cnt[1:0];
         end else begin
            sum_in = '0;
            bip_in = '0;
            if ((col_ff[2:0] != 3'd7) && !row_end) begin
               acc_in = acc_next;
               col_in = col_ff + 8'd1;
            end else begin
               push   = 1'b1;
               acc_in = '0;
               if (row_end) begin
                  col_in = '0;
                  row_in = row_ff + 8'd1;
                  pad_in = 2'd0 - phase_next;
               end else begin
                  col_in = col_ff + 8'd1;
               end
            end
         end
      end
   end

   // Result buffer: fill the output register first, spill into skid
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_xfer) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff) begin
         if (push && rsp_xfer) begin
            out_in = result;
         end else if (rsp_xfer) begin
            out_valid_in = 1'b0;
         end else if (push) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (push) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= bmc_pkg::RESET_IMAGE_WIDTH;
         height_ff     <= bmc_pkg::RESET_IMAGE_HEIGHT;
         bpp_ff        <= bmc_pkg::RESET_BYTES_PER_PIXEL;
         col_ff        <= '0;
         row_ff        <= '0;
         bip_ff        <= '0;
         sum_ff        <= '0;
         acc_ff        <= '0;
         phase_ff      <= '0;
         pad_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         bpp_ff        <= bpp_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         bip_ff        <= bip_in;
         sum_ff        <= sum_in;
         acc_ff        <= acc_in;
         phase_ff      <= phase_in;
         pad_ff        <= pad_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // The skid entry only fills behind a full output register
   `BMC_ASSERT(a_skid_behind_out, skid_valid_ff |-> out_valid_ff,
               "skid entry valid with empty output register")
   // A byte write is produced only while rows remain
   `BMC_ASSERT(a_push_in_image, push |-> (row_ff < height_ff) && req_xfer,
               "byte write produced outside the image")
   // Padding is skipped only between pixels
   `BMC_ASSERT(a_pad_between_pixels, (pad_ff != 2'd0) |-> (bip_ff == 2'd0 && sum_ff == '0),
               "padding pending inside a pixel")
   // A new result landing in the skid entry keeps the waiting one in place
   `BMC_ASSERT(a_skid_keeps_out, (out_valid_ff && !rsp_ready && push) |=>
               (skid_valid_ff && out_ff == $past(out_ff)),
               "stalled output overwritten by a new result")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for bmp_to_mono_bitmap_converter_core.
// Drives pixel bytes and register writes, predicts each byte write and checks it.
// Depends on bmc_pkg and the converter RTL only.
`timescale 1ns / 100ps

module testbench;

   localparam int RowBytesMax   = 32;
   localparam int DrainCycles   = 4;     // settling time after the last predicted write is seen
   localparam int WatchdogLimit = 4000;  // cycles with no transfer on any channel
   localparam int ItemsPerMix   = 80;

   // index with no register behind it; writes to it must change nothing
   localparam logic [bmc_pkg::CsrIdxWidth-1:0] CSR_UNUSED = 2'd3;

   logic                             clock;
   logic                             reset          = 1'b1;
   logic                             req_valid      = 1'b0;
   logic                             req_ready;
   logic [bmc_pkg::PixelWidth-1:0]   req_pixel_byte = '0;
   logic                             rsp_valid;
   logic                             rsp_ready      = 1'b0;
   logic [bmc_pkg::AddrWidth-1:0]    rsp_byte_address;
   logic [bmc_pkg::PixelWidth-1:0]   rsp_byte_value;
   logic                             rsp_last_of_image;
   logic                             csr_valid      = 1'b0;
   logic                             csr_ready;
   logic [bmc_pkg::CsrIdxWidth-1:0]  csr_index      = '0;
   logic [bmc_pkg::CsrDataWidth-1:0] csr_data       = '0;

   bmp_to_mono_bitmap_converter_core #(
      .MAX_ROW_BYTES(RowBytesMax)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_byte   (req_pixel_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_address (rsp_byte_address),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last_of_image(rsp_last_of_image),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Converter state as the block should hold it
   logic [bmc_pkg::DimWidth-1:0]   cfg_width  = bmc_pkg::RESET_IMAGE_WIDTH;
   logic [bmc_pkg::DimWidth-1:0]   cfg_height = bmc_pkg::RESET_IMAGE_HEIGHT;
   logic [bmc_pkg::BppWidth-1:0]   cfg_bpp    = bmc_pkg::RESET_BYTES_PER_PIXEL;
   logic [bmc_pkg::DimWidth-1:0]   col_cnt    = '0;
   logic [bmc_pkg::DimWidth-1:0]   row_cnt    = '0;
   logic [1:0]                     byte_idx   = '0;
   logic [bmc_pkg::SumWidth-1:0]   sum_acc    = '0;
   logic [bmc_pkg::PixelWidth-1:0] bits_acc   = '0;
   logic [1:0]                     phase      = '0;  // byte position within the row, mod 4
   logic [1:0]                     pad_left   = '0;

   bmc_pkg::result_type pending_writes[$];  // byte writes predicted but not yet seen on rsp

   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   int unsigned pixel_items    = 0;
   int unsigned ignored_items  = 0;
   int unsigned writes_checked = 0;
   int unsigned reg_writes     = 0;
   int unsigned error_count    = 0;
   int unsigned stall_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Advance the converter state by one pixel byte. Queue the byte write it
   // completes, if any. Return 0 when the byte is dropped because the image
   // is complete (row count at or past the height).
   function automatic bit convert_pixel_byte(input logic [bmc_pkg::PixelWidth-1:0] pix);
      int                  w;
      int                  bpp;
      int                  rb;
      int                  addr;
      bit                  black;
      bit                  row_end;
      bmc_pkg::result_type wr;
      w   = (cfg_width == '0) ? 1 : int'(cfg_width);
      bpp = (cfg_bpp == '0) ? 1 : ((cfg_bpp > 3'd4) ? 4 : int'(cfg_bpp));
      if (row_cnt >= cfg_height) return 1'b0;
      // skip row padding up to the next 4-byte boundary
      if (pad_left != 2'd0) begin
         pad_left = pad_left - 2'd1;
         phase    = phase + 2'd1;
         return 1'b1;
      end
      sum_acc = sum_acc + pix;
      phase   = phase + 2'd1;
      if (int'(byte_idx) + 1 < bpp) begin
         byte_idx = byte_idx + 2'd1;
         return 1'b1;
      end
      // pixel complete: black when the byte mean is below mid-scale
      black    = int'(sum_acc) < 128 * bpp;
      sum_acc  = '0;
      byte_idx = '0;
      if (black) bits_acc[col_cnt[2:0]] = 1'b1;
      row_end = int'(col_cnt) + 1 >= w;
      if (col_cnt[2:0] != 3'd7 && !row_end) begin
         col_cnt = col_cnt + 8'd1;
         return 1'b1;
      end
      // rows are stored bottom-up, so flip the row in the address
      rb = (w + 7) / 8;
      if (rb > RowBytesMax) rb = RowBytesMax;
      addr = (int'(cfg_height) - 1 - int'(row_cnt)) * rb + int'(col_cnt >> 3);
      wr.byte_address  = addr[bmc_pkg::AddrWidth-1:0];
      wr.byte_value    = bits_acc;
      wr.last_of_image = row_end && (int'(row_cnt) + 1 >= int'(cfg_height));
      pending_writes.push_back(wr);
      bits_acc = '0;
      if (row_end) begin
         col_cnt  = '0;
         row_cnt  = row_cnt + 8'd1;
         pad_left = 2'd0 - phase;
      end else begin
         col_cnt = col_cnt + 8'd1;
      end
      return 1'b1;
   endfunction

   // Mostly uniform bytes, with extra weight on the extremes and on the
   // region around the black/white threshold.
   function automatic logic [bmc_pkg::PixelWidth-1:0] pick_pixel_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'($urandom_range(120, 136));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send one pixel byte. Idle at random before raising valid, then hold
   // valid and data until the transfer.
   task automatic push_pixel_byte(input logic [bmc_pkg::PixelWidth-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (convert_pixel_byte(value)) pixel_items++;
      else ignored_items++;
   endtask

   // Drop valid and hold off until every predicted write has been seen, then
   // let the pipeline settle so a register write finds the block idle.
   task automatic wait_for_writes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [bmc_pkg::CsrIdxWidth-1:0]  index,
                                 input logic [bmc_pkg::CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         bmc_pkg::CSR_IMAGE_WIDTH:     cfg_width  = data;
         bmc_pkg::CSR_IMAGE_HEIGHT:    cfg_height = data;
         bmc_pkg::CSR_BYTES_PER_PIXEL: cfg_bpp    = data[bmc_pkg::BppWidth-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stream bytes until count more rows are done or the image is complete.
   // Pending padding of the previous row is consumed on the way.
   task automatic send_rows(input int unsigned count, input bit all_black);
      int unsigned target;
      target = int'(row_cnt) + count;
      while (row_cnt < target && row_cnt < cfg_height)
         push_pixel_byte(all_black ? 8'h00 : pick_pixel_byte());
   endtask

   // Reset values (8 x 8, 3 bytes per pixel): one row whose pixel sums sit
   // at and just below the threshold of 384, plus the byte extremes.
   task automatic test_reset_configuration();
      logic [bmc_pkg::PixelWidth-1:0] row_data [24] = '{
         8'd0,   8'd0,   8'd0,     8'd255, 8'd255, 8'd255,
         8'd127, 8'd128, 8'd128,   8'd128, 8'd128, 8'd128,
         8'd255, 8'd128, 8'd0,     8'd0,   8'd255, 8'd129,
         8'd1,   8'd127, 8'd255,   8'd255, 8'd255, 8'd255};
      foreach (row_data[i]) push_pixel_byte(row_data[i]);
      wait_for_writes();
   endtask

   // Widest row at the tallest image: row address near the top of the range
   // and all 32 bytes of a row, with one padding byte after 255 pixels.
   task automatic test_widest_row();
      write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'd255);
      write_register(bmc_pkg::CSR_IMAGE_HEIGHT, 8'd255);
      write_register(bmc_pkg::CSR_BYTES_PER_PIXEL, 8'd1);
      send_rows(1, 1'b0);
      push_pixel_byte(8'h5A);  // padding
      wait_for_writes();
   endtask

   // Every bytes-per-pixel setting but six, including zero (one byte) and values
   // above four (four bytes): one pixel just below and one at the threshold.
   task automatic test_pixel_formats();
      logic [bmc_pkg::BppWidth-1:0] formats [7] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7};
      int                           depth;
      write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'd2);
      foreach (formats[f]) begin
         write_register(bmc_pkg::CSR_BYTES_PER_PIXEL, 8'(formats[f]));
         write_register(bmc_pkg::CSR_IMAGE_HEIGHT, row_cnt + 8'd1);
         depth = (formats[f] == 3'd0) ? 1 : ((formats[f] > 3'd4) ? 4 : int'(formats[f]));
         while (pad_left != 2'd0) push_pixel_byte(8'hA5);
         for (int k = 0; k < depth; k++) push_pixel_byte((k == 0) ? 8'd127 : 8'd128);
         for (int k = 0; k < depth; k++) push_pixel_byte(8'd128);
         wait_for_writes();
      end
   endtask

   // Width zero acts as one pixel per row; a 9-pixel row leaves seven unused
   // bits in its last byte, which must read as zero even with all pixels black.
   task automatic test_narrow_rows();
      write_register(bmc_pkg::CSR_BYTES_PER_PIXEL, 8'd1);
      write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'd0);
      write_register(bmc_pkg::CSR_IMAGE_HEIGHT, row_cnt + 8'd3);
      send_rows(2, 1'b1);
      wait_for_writes();
      write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'd9);
      send_rows(1, 1'b1);
      wait_for_writes();
   endtask

   // Shrink the width under a half-built row: the column is already past the
   // new width, so the next pixel must end the row.
   task automatic test_mid_row_width_change();
      write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'd16);
      write_register(bmc_pkg::CSR_IMAGE_HEIGHT, row_cnt + 8'd1);
      while (pad_left != 2'd0) push_pixel_byte(8'h33);
      push_pixel_byte(8'd0);
      push_pixel_byte(8'd255);
      push_pixel_byte(8'd0);
      push_pixel_byte(8'd255);
      push_pixel_byte(8'd0);
      wait_for_writes();
      write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'd3);
      push_pixel_byte(8'd0);
      wait_for_writes();
   endtask

   // A complete image, height zero and a height below the row count all drop
   // bytes; raising the height again resumes with the pending padding.
   task automatic test_image_complete();
      repeat (3) push_pixel_byte(pick_pixel_byte());
      wait_for_writes();
      write_register(bmc_pkg::CSR_IMAGE_HEIGHT, 8'd0);
      repeat (2) push_pixel_byte(pick_pixel_byte());
      wait_for_writes();
      write_register(bmc_pkg::CSR_IMAGE_HEIGHT, 8'd1);
      repeat (2) push_pixel_byte(pick_pixel_byte());
      wait_for_writes();
      write_register(CSR_UNUSED, 8'hFF);
      write_register(bmc_pkg::CSR_IMAGE_HEIGHT, row_cnt + 8'd2);
      send_rows(1, 1'b0);
      wait_for_writes();
      write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'd1);
      send_rows(1, 1'b0);
      wait_for_writes();
   endtask

   // One random image: mostly complete images, some cut short (leaving a
   // half-built row for the next settings) and some that only feed bytes to
   // a finished image.
   task automatic run_random_image();
      int unsigned kind;
      int unsigned rows;
      int unsigned nbytes;
      kind = $urandom_range(0, 9);
      rows = $urandom_range(1, 3);
      write_register(bmc_pkg::CSR_BYTES_PER_PIXEL, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0) begin
         write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'($urandom_range(100, 255)));
         rows = 1;
      end else begin
         write_register(bmc_pkg::CSR_IMAGE_WIDTH, 8'($urandom_range(0, 20)));
      end
      if ($urandom_range(0, 7) == 0) write_register(CSR_UNUSED, 8'($urandom_range(0, 255)));
      if (kind == 9) begin
         write_register(bmc_pkg::CSR_IMAGE_HEIGHT, 8'($urandom_range(0, row_cnt)));
         repeat ($urandom_range(1, 4)) push_pixel_byte(pick_pixel_byte());
      end else begin
         write_register(bmc_pkg::CSR_IMAGE_HEIGHT, row_cnt + 8'(rows));
         if (kind < 7) begin
            send_rows(rows, 1'b0);
            repeat ($urandom_range(0, 2)) push_pixel_byte(pick_pixel_byte());
         end else begin
            nbytes = $urandom_range(1, 40);
            while (nbytes != 0 && row_cnt < cfg_height) begin
               push_pixel_byte(pick_pixel_byte());
               nbytes--;
            end
         end
      end
      // hold the sender until every write is back before the next settings
      wait_for_writes();
   endtask

   task automatic test_random_images(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned min_writes);
      int unsigned start_items;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start_items   = pixel_items;
      // stop short of the 8-bit row count so later images still have rows
      while ((pixel_items - start_items < ItemsPerMix || writes_checked < min_writes)
             && row_cnt < 8'd240)
         run_random_image();
   endtask

   // Receiver: stall at random, at the rate of the current idle mix
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Compare each write transfer against the oldest prediction
   always @(posedge clock) begin
      bmc_pkg::result_type exp_wr;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected byte write: address %0d value 0x%02h last %0b",
                   rsp_byte_address, rsp_byte_value, rsp_last_of_image);
            error_count++;
         end else begin
            exp_wr = pending_writes.pop_front();
            writes_checked++;
            if (rsp_byte_address !== exp_wr.byte_address) begin
               $error("byte_address: expected %0d, got %0d",
                      exp_wr.byte_address, rsp_byte_address);
               error_count++;
            end
            if (rsp_byte_value !== exp_wr.byte_value) begin
               $error("byte_value: expected 0x%02h, got 0x%02h",
                      exp_wr.byte_value, rsp_byte_value);
               error_count++;
            end
            if (rsp_last_of_image !== exp_wr.last_of_image) begin
               $error("last_of_image: expected %0b, got %0b",
                      exp_wr.last_of_image, rsp_last_of_image);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no channel sees a transfer for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      // hold reset, then release it on a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed tests run under the first idle mix
      send_idle_pct = 37;
      recv_idle_pct = 80;
      test_reset_configuration();
      test_widest_row();
      test_pixel_formats();
      test_narrow_rows();
      test_mid_row_width_change();
      test_image_complete();

      // random images: receiver-heavy idling, then sender-heavy, then none
      test_random_images(37, 80, 0);
      test_random_images(80, 37, 0);
      test_random_images(0, 0, 60);

      // drain, then give a stray late write time to show up
      wait_for_writes();
      if (pending_writes.size() != 0) begin
         $error("%0d byte writes never arrived", pending_writes.size());
         error_count++;
      end
      $display("Converted %0d pixel bytes (%0d more dropped) into %0d checked byte writes,",
               pixel_items, ignored_items, writes_checked);
      $display("with %0d register writes over all pixel formats, widths and idle mixes.",
               reg_writes);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
